// File: rtl/lqmax_pkg.sv
// shared types and codes for the linear queue with maximum query
package lqmax_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;

  localparam logic [1:0] KIND_ENQ   = 2'd0;
  localparam logic [1:0] KIND_DEQ   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] popped_value;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] max_value;
    logic                    is_empty;
    logic                    is_full;
  } out_beat_t;

  // running scan result handed from cell to cell
  typedef struct packed {
    logic                    tok;
    logic                    have;
    logic signed [VAL_W-1:0] maxv;
    logic signed [VAL_W-1:0] front;
    logic signed [VAL_W-1:0] popped;
  } scan_t;

  // per-cell control decoded at the top level
  typedef struct packed {
    logic wr_en;
    logic held;
    logic pop_hit;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

endpackage

// File: rtl/lqmax_cell.sv
// one queue slot with its stage of the running maximum scan
module lqmax_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lqmax_pkg::cell_ctl_t              ctl,
  input  logic signed [lqmax_pkg::VAL_W-1:0] wr_data,
  input  lqmax_pkg::scan_t                  scan_in,
  output lqmax_pkg::scan_t                  scan_out
);

  logic signed [lqmax_pkg::VAL_W-1:0] slot_r;
  logic                               tok_r;
  logic                               have_r;
  logic signed [lqmax_pkg::VAL_W-1:0] maxv_r;
  logic signed [lqmax_pkg::VAL_W-1:0] front_r;
  logic signed [lqmax_pkg::VAL_W-1:0] popped_r;

  logic                               have_nxt;
  logic signed [lqmax_pkg::VAL_W-1:0] maxv_nxt;
  logic signed [lqmax_pkg::VAL_W-1:0] front_nxt;
  logic signed [lqmax_pkg::VAL_W-1:0] popped_nxt;

  always_comb begin
    have_nxt   = scan_in.have | ctl.held;
    maxv_nxt   = scan_in.maxv;
    front_nxt  = scan_in.front;
    popped_nxt = ctl.pop_hit ? slot_r : scan_in.popped;
    if (ctl.held) begin
      if (!scan_in.have) begin
        // first held slot is the head
        maxv_nxt  = slot_r;
        front_nxt = slot_r;
      end else if (slot_r > scan_in.maxv) begin
        maxv_nxt = slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      slot_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= scan_in.tok;
    end
  end

  // data holds once the token has passed, so the chain end stays readable
  always_ff @(posedge clk) begin
    if (scan_in.tok) begin
      have_r   <= have_nxt;
      maxv_r   <= maxv_nxt;
      front_r  <= front_nxt;
      popped_r <= popped_nxt;
    end
  end

  assign scan_out.tok    = tok_r;
  assign scan_out.have   = have_r;
  assign scan_out.maxv   = maxv_r;
  assign scan_out.front  = front_r;
  assign scan_out.popped = popped_r;

endmodule

// File: rtl/linear_queue_with_max_query.sv
// top level: linear array queue of signed values with a maximum query
// An item (enqueue, dequeue or status query) is taken when the block is idle.
// The queue pointers and the slot write update at the accept edge; then a
// token walks down a row of DEPTH cells, one cell per cycle, carrying the
// running maximum, the head value and the dequeued value. The result beat is
// loaded into the output register once the token has left the last cell and
// the register is free, and the next input beat can be accepted in the cycle
// after the result enters the output register, so the block takes one item
// at a time. A finished result waits in the output register while the next
// item is already being worked on. Slots are written once
// only: the write count never falls, so the queue reports full once DEPTH
// values have been written, even after dequeues. An empty queue reports zero
// for the front and maximum values with is_empty set; kind code 3 acts as a
// status query.
module linear_queue_with_max_query #(
  parameter int DEPTH = lqmax_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lqmax_pkg::in_beat_t  in_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lqmax_pkg::out_beat_t out_beat
);

  localparam int IW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] DEPTH_IW = IW'(DEPTH);

  // queue pointers, counts from 0 up to DEPTH
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     wr_r, wr_nxt;
  logic [IW-1:0]     pop_idx_r;
  logic              pop_en_r;
  logic [1:0]        status_r, status_nxt;
  logic              start_r;
  lqmax_pkg::state_t state_r, state_nxt;

  logic                 out_valid_r;
  lqmax_pkg::out_beat_t out_beat_r;

  logic accept;
  logic full, empty;
  logic enq_ok, deq_ok;
  logic out_free;
  logic load_out;

  lqmax_pkg::scan_t     chain [DEPTH+1];
  lqmax_pkg::cell_ctl_t ctl   [DEPTH];

  assign full     = (wr_r == DEPTH_IW);
  assign empty    = (head_r >= wr_r);
  assign in_ready = (state_r == lqmax_pkg::ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign enq_ok = (in_beat.kind == lqmax_pkg::KIND_ENQ) && !full;
  assign deq_ok = (in_beat.kind == lqmax_pkg::KIND_DEQ) && !empty;

  always_comb begin
    head_nxt   = head_r;
    wr_nxt     = wr_r;
    status_nxt = lqmax_pkg::STAT_OK;
    case (in_beat.kind)
      lqmax_pkg::KIND_ENQ: begin
        if (full) begin
          status_nxt = lqmax_pkg::STAT_FULL;
        end else begin
          wr_nxt = wr_r + IW'(1);
        end
      end
      lqmax_pkg::KIND_DEQ: begin
        if (empty) begin
          status_nxt = lqmax_pkg::STAT_EMPTY;
        end else begin
          head_nxt = head_r + IW'(1);
        end
      end
      default: begin
        // status query: nothing moves
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      wr_r    <= '0;
      start_r <= 1'b0;
    end else begin
      start_r <= accept;
      if (accept) begin
        head_r <= head_nxt;
        wr_r   <= wr_nxt;
      end
    end
  end

  // per-item bookkeeping, meaningful only while its scan runs
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      pop_en_r  <= deq_ok;
      pop_idx_r <= head_r;
    end
  end

  // chain head: token enters with nothing found yet
  assign chain[0].tok    = start_r;
  assign chain[0].have   = 1'b0;
  assign chain[0].maxv   = '0;
  assign chain[0].front  = '0;
  assign chain[0].popped = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [IW-1:0] IDX = IW'(i);

    // a slot is held when it lies between head and write position
    assign ctl[i].wr_en   = accept && enq_ok && (wr_r == IDX);
    assign ctl[i].held    = (IDX >= head_r) && (IDX < wr_r);
    assign ctl[i].pop_hit = pop_en_r && (pop_idx_r == IDX);

    lqmax_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[i]),
      .wr_data  (in_beat.value),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  // sequencer: wait for the token to leave the last cell, then hand off
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      lqmax_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = lqmax_pkg::ST_SCAN;
        end
      end
      lqmax_pkg::ST_SCAN: begin
        if (chain[DEPTH].tok) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = lqmax_pkg::ST_IDLE;
          end else begin
            state_nxt = lqmax_pkg::ST_HOLD;
          end
        end
      end
      lqmax_pkg::ST_HOLD: begin
        // chain end keeps its data until the next token
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = lqmax_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lqmax_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lqmax_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_beat_r.status       <= status_r;
      out_beat_r.popped_value <= pop_en_r ? chain[DEPTH].popped : '0;
      out_beat_r.front_value  <= chain[DEPTH].have ? chain[DEPTH].front : '0;
      out_beat_r.max_value    <= chain[DEPTH].have ? chain[DEPTH].maxv : '0;
      out_beat_r.is_empty     <= empty;
      out_beat_r.is_full      <= full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// File: rtl/lqmax_checker.sv
// port-level checks for the linear queue with maximum query, bound to the top
module lqmax_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input lqmax_pkg::in_beat_t  in_beat,
  input logic                 out_valid,
  input logic                 out_ready,
  input lqmax_pkg::out_beat_t out_beat
);

  // a result beat is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("result beat dropped or changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // empty queue reports zero front and maximum
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.is_empty |->
      out_beat.front_value == '0 && out_beat.max_value == '0)
    else $error("empty queue with nonzero front or maximum");

  // rejected enqueue only when full
  a_full_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.status == lqmax_pkg::STAT_FULL |-> out_beat.is_full)
    else $error("enqueue rejected while not full");

  // dequeue on empty pops nothing and leaves the queue empty
  a_empty_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.status == lqmax_pkg::STAT_EMPTY |->
      out_beat.is_empty && out_beat.popped_value == '0)
    else $error("failed dequeue with data or nonempty queue");

endmodule

bind linear_queue_with_max_query lqmax_checker u_lqmax_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);

// File: tb/sv/testbench.sv
// testbench for the linear queue with maximum query: scoreboard, drivers and checks
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lqmax_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  // one pass down the scan chain plus slack for the output register
  localparam int DRAIN_CYCLES = 2 * DEPTH + 10;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 345;

  // expected results are worked out here from each accepted input beat
  class lq_scoreboard;
    logic signed [VAL_W-1:0] slots [DEPTH];
    int unsigned head;
    int unsigned written;
    out_beat_t expected_beats [$];
    int errors;

    function new();
      head = 0;
      written = 0;
      errors = 0;
    endfunction

    // one queue step: update pointers, then scan head..last written for the maximum
    function out_beat_t next_result(in_beat_t b);
      out_beat_t r;
      r = '0;
      r.status = STAT_OK;
      case (b.kind)
        KIND_ENQ: begin
          if (written >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            slots[written] = b.value;
            written++;
          end
        end
        KIND_DEQ: begin
          if (head >= written) begin
            r.status = STAT_EMPTY;
          end else begin
            r.popped_value = slots[head];
            head++;
          end
        end
        default: ;  // status query, kind code 3 included
      endcase
      if (head < written) begin
        r.front_value = slots[head];
        r.max_value = slots[head];
        for (int unsigned i = head + 1; i < written; i++) begin
          if (slots[i] > r.max_value) r.max_value = slots[i];
        end
      end
      r.is_empty = (head >= written);
      r.is_full = (written >= DEPTH);
      return r;
    endfunction

    function void note_item(in_beat_t b);
      expected_beats.push_back(next_result(b));
    endfunction

    function void field_mismatch(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, got);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        field_mismatch("status", VAL_W'(want.status), VAL_W'(got.status));
        field_mismatch("popped_value", want.popped_value, got.popped_value);
        field_mismatch("front_value", want.front_value, got.front_value);
        field_mismatch("max_value", want.max_value, got.max_value);
        field_mismatch("is_empty", VAL_W'(want.is_empty), VAL_W'(got.is_empty));
        field_mismatch("is_full", VAL_W'(want.is_full), VAL_W'(got.is_full));
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_beat;

  lq_scoreboard board;

  // idle percentages per side, changed between phases
  int send_idle_pct;
  int recv_idle_pct;
  // request from the stimulus for one long receiver stall
  bit long_hold_req;

  linear_queue_with_max_query #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_beat(out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // offer one beat from a falling edge, with random idle cycles first;
  // returns on the falling edge after acceptance with in_valid still high
  task automatic send_beat(input logic [1:0] kind, input logic signed [VAL_W-1:0] value);
    in_beat_t b;
    b.kind = kind;
    b.value = value;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (!in_ready);
    board.note_item(b);
    @(negedge clk);
  endtask

  // drop valid and hold off until every expected result beat has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.expected_beats.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    logic [1:0] kind;
    logic signed [VAL_W-1:0] value;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      // mostly enqueue and dequeue, some queries and the unused code
      if (pick < 40) kind = KIND_ENQ;
      else if (pick < 75) kind = KIND_DEQ;
      else if (pick < 90) kind = KIND_QUERY;
      else kind = 2'd3;
      case ($urandom_range(0, 15))
        0: value = 32'sh7fffffff;
        1: value = 32'sh80000000;
        2: value = '0;
        3: value = -32'sd1;
        default: value = $urandom;
      endcase
      send_beat(kind, value);
    end
  endtask

  // receiver: random back-pressure plus one long stall on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_result(out_beat);
    end
  end

  // overall time limit
  initial begin
    #400000;
    $display("linear_queue_with_max_query test failed");
    $finish;
  end

  initial begin
    int waited;
    board = new();
    send_idle_pct = 37;
    recv_idle_pct = 51;
    long_hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty-queue cases, unused kind code, value extremes, draining
    send_beat(KIND_DEQ, 32'sd5);
    send_beat(KIND_QUERY, -32'sd1);
    send_beat(2'd3, 32'sh7fffffff);
    send_beat(KIND_ENQ, 32'sh7fffffff);
    send_beat(KIND_ENQ, 32'sh80000000);
    send_beat(KIND_QUERY, '0);
    send_beat(KIND_DEQ, '0);
    send_beat(KIND_ENQ, '0);
    send_beat(KIND_ENQ, -32'sd1);
    send_beat(2'd3, 32'sh80000000);
    send_beat(KIND_DEQ, 32'sh7fffffff);
    send_beat(KIND_DEQ, -32'sd1);
    send_beat(KIND_DEQ, '0);
    send_beat(KIND_DEQ, 32'sh55555555);

    // long receiver stall while beats keep coming, so the block backs up
    long_hold_req = 1'b1;
    random_phase(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 51;
    recv_idle_pct = 37;
    random_phase(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(PHASE_ITEMS);
    in_valid <= 1'b0;

    waited = 0;
    while (board.expected_beats.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.expected_beats.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time,
               board.expected_beats.size());
      board.errors++;
    end

    if (board.errors == 0) begin
      $display("linear_queue_with_max_query test passed");
    end else begin
      $display("linear_queue_with_max_query test failed");
    end
    $finish;
  end

endmodule
